/* rtl/tbpc_pkg.sv */
package tbpc_pkg;

   // button lanes, scanned up, ok, down
   localparam int NUM_BUTTONS = 3;

   localparam int TIME_W = 32;
   localparam int CFG_W  = 16;
   localparam int EV_W   = 3;

   // event codes
   localparam logic [EV_W-1:0] EV_NONE       = 3'd0;
   localparam logic [EV_W-1:0] EV_SHORT_BASE = 3'd1;
   localparam logic [EV_W-1:0] EV_LONG_BASE  = 3'd4;
   localparam logic [EV_W-1:0] EV_PANIC      = 3'd7;

   // control register indexes
   localparam logic [1:0] REG_DEBOUNCE   = 2'd0;
   localparam logic [1:0] REG_LONG_PRESS = 2'd1;
   localparam logic [1:0] REG_PANIC_HOLD = 2'd2;

   // register reset values in ms
   localparam logic [CFG_W-1:0] DEBOUNCE_DEFAULT   = 16'd50;
   localparam logic [CFG_W-1:0] LONG_PRESS_DEFAULT = 16'd800;
   localparam logic [CFG_W-1:0] PANIC_HOLD_DEFAULT = 16'd3000;

   // what one lane reports for the current word
   typedef struct packed {
      logic pressed;   // debounced state after this word
      logic short_ev;  // release without a long event
      logic long_ev;   // hold reached the long-press time
   } lane_result_type;

endpackage

/* rtl/three_button_press_classifier.sv */
// Channel | Direction | Handshake           | Payload
// req     | in        | req_tvalid/tready   | tdata: now_ms, levels; tuser: clear
// rsp     | out       | rsp_tvalid/tready   | tdata: event_code, held flags
// csr     | in        | csr_wr_en           | csr_index, csr_wdata
//
// One word per cycle while req_tready is high; each result word is registered.
// Lane and panic state update in the accept cycle, so words follow back to back.
// An output register plus a one-word skid stage let the input run while
// the output stalls; req_tready drops only when the skid word is held.
// Synchronous reset clears all flags, timers and the output stage.
module three_button_press_classifier (
   input  logic                          clock,
   input  logic                          reset,
   // bits: now_ms[31:0], level_up[32], level_ok[33], level_down[34], zero pad
   input  logic [39:0]                   req_tdata,
   // bits: clear[0]
   input  logic                          req_tuser,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // bits: event_code[2:0], held_up[3], held_ok[4], held_down[5], zero pad
   output logic [7:0]                    rsp_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic                          csr_wr_en,
   input  logic [1:0]                    csr_index,
   input  logic [tbpc_pkg::CFG_W-1:0]    csr_wdata
);
   import tbpc_pkg::*;

   logic [CFG_W-1:0] debounce_ff, debounce_in;
   logic [CFG_W-1:0] long_press_ff, long_press_in;
   logic [CFG_W-1:0] panic_hold_ff, panic_hold_in;

   logic                accept;
   logic                take;
   logic [TIME_W-1:0]   now_ms;
   logic [NUM_BUTTONS-1:0] lvl_pressed;
   lane_result_type     lanes [NUM_BUTTONS];
   logic [EV_W-1:0]     event_code;
   logic [7:0]          word;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_data_ff, rsp_data_in;
   logic       skid_valid_ff, skid_valid_in;
   logic [7:0] skid_data_ff, skid_data_in;

   // control registers
   always_comb begin
      debounce_in   = debounce_ff;
      long_press_in = long_press_ff;
      panic_hold_in = panic_hold_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_DEBOUNCE:   debounce_in   = csr_wdata;
            REG_LONG_PRESS: long_press_in = csr_wdata;
            REG_PANIC_HOLD: panic_hold_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff   <= DEBOUNCE_DEFAULT;
         long_press_ff <= LONG_PRESS_DEFAULT;
         panic_hold_ff <= PANIC_HOLD_DEFAULT;
      end else begin
         debounce_ff   <= debounce_in;
         long_press_ff <= long_press_in;
         panic_hold_ff <= panic_hold_in;
      end
   end

   // input unpack; pins are active low
   assign accept      = req_tvalid && req_tready;
   assign take        = rsp_tvalid && rsp_tready;
   assign now_ms      = req_tdata[TIME_W-1:0];
   assign lvl_pressed = ~req_tdata[TIME_W+NUM_BUTTONS-1:TIME_W];

   // one lane per button
   for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
      tbpc_lane u_lane (
         .clock           (clock),
         .reset           (reset),
         .step_en         (accept),
         .clear           (req_tuser),
         .now_ms          (now_ms),
         .lvl_pressed     (lvl_pressed[b]),
         .debounce_time   (debounce_ff),
         .long_press_time (long_press_ff),
         .result          (lanes[b])
      );
   end

   tbpc_merge u_merge (
      .clock           (clock),
      .reset           (reset),
      .step_en         (accept),
      .now_ms          (now_ms),
      .panic_hold_time (panic_hold_ff),
      .lanes           (lanes),
      .event_code      (event_code)
   );

   // result word
   assign word = {2'b00, lanes[2].pressed, lanes[1].pressed, lanes[0].pressed, event_code};

   // output register with skid stage
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (take) begin
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!rsp_valid_ff || take) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = word;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = word;
         end
      end else if (take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign req_tready = !skid_valid_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid word held with output register empty");

   a_accept_gives_word: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted word did not reach the output");

   a_clear_word_zero: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser && (!rsp_valid_ff || take)) |=> (rsp_tdata == 8'd0))
      else $error("clear word not all zero");

endmodule

/* rtl/tbpc_lane.sv */
module tbpc_lane (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             step_en,
   input  logic                             clear,
   input  logic [tbpc_pkg::TIME_W-1:0]      now_ms,
   input  logic                             lvl_pressed,
   input  logic [tbpc_pkg::CFG_W-1:0]       debounce_time,
   input  logic [tbpc_pkg::CFG_W-1:0]       long_press_time,
   output tbpc_pkg::lane_result_type        result
);
   import tbpc_pkg::*;

   logic              pressed_ff, pressed_in;
   logic              long_fired_ff, long_fired_in;
   logic [TIME_W-1:0] last_change_ff, last_change_in;
   logic [TIME_W-1:0] press_start_ff, press_start_in;

   logic [TIME_W-1:0] change_diff;
   logic [TIME_W-1:0] hold_diff;
   logic              change_ok;
   logic              acc_press;
   logic              acc_rel;
   logic              pressed_mid;
   logic              long_fired_mid;
   logic              long_ok;
   logic              long_hit;

   // debounce: accept a level change only after the quiet time
   always_comb begin
      change_diff = now_ms - last_change_ff;
      change_ok   = (lvl_pressed != pressed_ff) &&
                    (change_diff >= {{(TIME_W-CFG_W){1'b0}}, debounce_time});
      acc_press   = change_ok && lvl_pressed;
      acc_rel     = change_ok && !lvl_pressed;
      pressed_mid = change_ok ? lvl_pressed : pressed_ff;
      long_fired_mid = acc_press ? 1'b0 : long_fired_ff;
   end

   // long press; a fresh press has zero hold time
   always_comb begin
      hold_diff = now_ms - press_start_ff;
      if (acc_press) begin
         long_ok = (long_press_time == '0);
      end else begin
         long_ok = (hold_diff >= {{(TIME_W-CFG_W){1'b0}}, long_press_time});
      end
      long_hit = pressed_mid && !long_fired_mid && long_ok;
   end

   // lane report
   always_comb begin
      if (clear) begin
         result = '0;
      end else begin
         result.pressed  = pressed_mid;
         result.short_ev = acc_rel && !long_fired_ff;
         result.long_ev  = long_hit;
      end
   end

   // next state
   always_comb begin
      pressed_in     = pressed_ff;
      long_fired_in  = long_fired_ff;
      last_change_in = last_change_ff;
      press_start_in = press_start_ff;
      if (step_en) begin
         if (clear) begin
            pressed_in    = 1'b0;
            long_fired_in = 1'b0;
         end else begin
            pressed_in    = pressed_mid;
            long_fired_in = long_fired_mid || long_hit;
            if (change_ok) begin
               last_change_in = now_ms;
            end
            if (acc_press) begin
               press_start_in = now_ms;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pressed_ff     <= 1'b0;
         long_fired_ff  <= 1'b0;
         last_change_ff <= '0;
         press_start_ff <= '0;
      end else begin
         pressed_ff     <= pressed_in;
         long_fired_ff  <= long_fired_in;
         last_change_ff <= last_change_in;
         press_start_ff <= press_start_in;
      end
   end

endmodule

/* rtl/tbpc_merge.sv */
module tbpc_merge (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             step_en,
   input  logic [tbpc_pkg::TIME_W-1:0]      now_ms,
   input  logic [tbpc_pkg::CFG_W-1:0]       panic_hold_time,
   input  tbpc_pkg::lane_result_type        lanes [tbpc_pkg::NUM_BUTTONS],
   output logic [tbpc_pkg::EV_W-1:0]        event_code
);
   import tbpc_pkg::*;

   logic              panic_timing_ff, panic_timing_in;
   logic [TIME_W-1:0] panic_start_ff, panic_start_in;

   logic              all_held;
   logic [TIME_W-1:0] panic_diff;
   logic              panic_ok;

   // panic hold check
   always_comb begin
      all_held = 1'b1;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
         all_held = all_held && lanes[b].pressed;
      end
      panic_diff = now_ms - panic_start_ff;
      panic_ok   = panic_timing_ff &&
                   (panic_diff >= {{(TIME_W-CFG_W){1'b0}}, panic_hold_time});
   end

   // last lane in scan order wins, panic beats all
   always_comb begin
      event_code = EV_NONE;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
         if (lanes[b].short_ev) begin
            event_code = EV_SHORT_BASE + EV_W'(b);
         end
         if (lanes[b].long_ev) begin
            event_code = EV_LONG_BASE + EV_W'(b);
         end
      end
      if (all_held && panic_ok) begin
         event_code = EV_PANIC;
      end
   end

   // panic timer: starts on the first all-held word, stops on fire or release
   always_comb begin
      panic_timing_in = panic_timing_ff;
      panic_start_in  = panic_start_ff;
      if (step_en) begin
         if (all_held) begin
            if (!panic_timing_ff) begin
               panic_timing_in = 1'b1;
               panic_start_in  = now_ms;
            end else if (panic_ok) begin
               panic_timing_in = 1'b0;
            end
         end else begin
            panic_timing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         panic_timing_ff <= 1'b0;
      end else begin
         panic_timing_ff <= panic_timing_in;
      end
      panic_start_ff <= panic_start_in;
   end

   a_panic_needs_all_held: assert property (@(posedge clock) disable iff (reset)
      (event_code == EV_PANIC) |-> all_held)
      else $error("panic without all buttons held");

   a_panic_needs_timer: assert property (@(posedge clock) disable iff (reset)
      (event_code == EV_PANIC) |-> panic_timing_ff)
      else $error("panic while timer idle");

   a_panic_stops_timer: assert property (@(posedge clock) disable iff (reset)
      (step_en && event_code == EV_PANIC) |=> !panic_timing_ff)
      else $error("panic timer kept running after panic");

endmodule

/* dv/tb.sv */
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tbpc_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam int PRINT_LIMIT = 40;
   // pin levels are active low
   localparam logic PRESS = 1'b0;
   localparam logic FREE  = 1'b1;

   typedef struct {
      logic [EV_W-1:0] event_code;
      logic            held_up;
      logic            held_ok;
      logic            held_down;
   } press_result_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic [39:0]       req_tdata = '0;   // now_ms[31:0], level_up, level_ok, level_down, pad
   logic              req_tuser = 1'b0; // clear
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [7:0]        rsp_tdata;        // event_code[2:0], held_up, held_ok, held_down, pad
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic              csr_wr_en = 1'b0;
   logic [1:0]        csr_index = '0;
   logic [CFG_W-1:0]  csr_wdata = '0;

   three_button_press_classifier dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // press classifier prediction
   // ---------------------------------------------------------------
   logic [CFG_W-1:0]  debounce_cfg;
   logic [CFG_W-1:0]  long_cfg;
   logic [CFG_W-1:0]  panic_cfg;
   logic              btn_held [NUM_BUTTONS];
   logic [31:0]       last_edge_ms [NUM_BUTTONS];
   logic [31:0]       hold_start_ms [NUM_BUTTONS];
   logic              long_sent [NUM_BUTTONS];
   logic [31:0]       panic_since_ms;
   logic              panic_armed;

   press_result_type  pending_results [$];

   int                fail_count = 0;
   int                polls_sent = 0;
   int                clears_sent = 0;
   int                results_checked = 0;
   int                input_stall_cycles = 0;
   int                event_tally [8];

   // stimulus pacing
   logic              sender_idle_en = 1'b1;
   logic              receiver_idle_en = 1'b1;
   int                sender_calm_left = 0;
   int                rsp_hold_left = 0;
   int                rsp_stall_left = 0;
   int                rsp_run_left = 0;
   int                cycle_count = 0;

   // random stream state
   logic [31:0]       stream_ms = '0;
   logic              target_pressed [NUM_BUTTONS];
   int                chord_left = 0;

   task automatic reset_predictor();
      debounce_cfg = DEBOUNCE_DEFAULT;
      long_cfg     = LONG_PRESS_DEFAULT;
      panic_cfg    = PANIC_HOLD_DEFAULT;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
         btn_held[b]       = 1'b0;
         last_edge_ms[b]   = '0;
         hold_start_ms[b]  = '0;
         long_sent[b]      = 1'b0;
         target_pressed[b] = 1'b0;
      end
      panic_since_ms = '0;
      panic_armed    = 1'b0;
      for (int c = 0; c < 8; c++) event_tally[c] = 0;
   endtask

   // one poll: debounce each lane, classify short/long, then panic on top
   function automatic press_result_type classify_poll(input logic [31:0] now_ms,
                                                      input logic lvl_up, lvl_ok, lvl_down,
                                                      input logic clr);
      press_result_type r;
      logic          pin_pressed [NUM_BUTTONS];
      logic [31:0]   since_ms;
      logic [EV_W-1:0] code;
      code = EV_NONE;
      pin_pressed[0] = !lvl_up;
      pin_pressed[1] = !lvl_ok;
      pin_pressed[2] = !lvl_down;
      if (clr) begin
         for (int b = 0; b < NUM_BUTTONS; b++) begin
            btn_held[b]  = 1'b0;
            long_sent[b] = 1'b0;
         end
         panic_armed    = 1'b0;
         panic_since_ms = '0;
      end else begin
         for (int b = 0; b < NUM_BUTTONS; b++) begin
            since_ms = now_ms - last_edge_ms[b];
            if (pin_pressed[b] != btn_held[b] && since_ms >= 32'(debounce_cfg)) begin
               btn_held[b]     = pin_pressed[b];
               last_edge_ms[b] = now_ms;
               if (pin_pressed[b]) begin
                  hold_start_ms[b] = now_ms;
                  long_sent[b]     = 1'b0;
               end else if (!long_sent[b]) begin
                  code = EV_SHORT_BASE + EV_W'(b);
               end
            end
            since_ms = now_ms - hold_start_ms[b];
            if (btn_held[b] && !long_sent[b] && since_ms >= 32'(long_cfg)) begin
               long_sent[b] = 1'b1;
               code = EV_LONG_BASE + EV_W'(b);
            end
         end
         // all three held: arm on first poll, fire once the hold time is reached
         if (btn_held[0] && btn_held[1] && btn_held[2]) begin
            since_ms = now_ms - panic_since_ms;
            if (!panic_armed) begin
               panic_armed    = 1'b1;
               panic_since_ms = now_ms;
            end else if (since_ms >= 32'(panic_cfg)) begin
               panic_armed    = 1'b0;
               panic_since_ms = '0;
               code = EV_PANIC;
            end
         end else begin
            panic_armed    = 1'b0;
            panic_since_ms = '0;
         end
      end
      r.event_code = code;
      r.held_up    = btn_held[0];
      r.held_ok    = btn_held[1];
      r.held_down  = btn_held[2];
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      if (fail_count < PRINT_LIMIT) $display("[%0t] ERROR: %s", $realtime, msg);
      fail_count++;
   endtask

   // ---------------------------------------------------------------
   // result side: random stalls, long hold-off on request
   // ---------------------------------------------------------------
   always @(posedge clock) begin : drive_receiver
      if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_tready <= 1'b0;
      end else if (!receiver_idle_en || rsp_run_left > 0) begin
         if (rsp_run_left > 0) rsp_run_left--;
         rsp_tready <= 1'b1;
      end else if (rsp_stall_left > 0) begin
         rsp_stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         case ($urandom_range(0, 15))
            0, 1: rsp_stall_left = $urandom_range(1, 11);
            2: rsp_run_left = $urandom_range(20, 80);
            default: ;
         endcase
      end
   end

   // compare each result word with the oldest prediction
   always @(posedge clock) begin : check_results
      press_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result word 0x%02h with no poll pending", rsp_tdata));
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[2:0] !== want.event_code)
               report_mismatch($sformatf("result %0d event_code got %0d want %0d",
                                         results_checked, rsp_tdata[2:0], want.event_code));
            if (rsp_tdata[3] !== want.held_up)
               report_mismatch($sformatf("result %0d held_up got %b want %b",
                                         results_checked, rsp_tdata[3], want.held_up));
            if (rsp_tdata[4] !== want.held_ok)
               report_mismatch($sformatf("result %0d held_ok got %b want %b",
                                         results_checked, rsp_tdata[4], want.held_ok));
            if (rsp_tdata[5] !== want.held_down)
               report_mismatch($sformatf("result %0d held_down got %b want %b",
                                         results_checked, rsp_tdata[5], want.held_down));
            if (rsp_tdata[7:6] !== 2'b00)
               report_mismatch($sformatf("result %0d pad bits %b not zero",
                                         results_checked, rsp_tdata[7:6]));
            event_tally[want.event_code]++;
            results_checked++;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("watchdog: no progress after %0d cycles, %0d results pending",
                  cycle_count, pending_results.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // shared stimulus tasks
   // ---------------------------------------------------------------
   task automatic send_poll(input logic [31:0] now_ms,
                            input logic lvl_up, lvl_ok, lvl_down, clr);
      int gap;
      gap = 0;
      if (sender_idle_en) begin
         if (sender_calm_left > 0) sender_calm_left--;
         else case ($urandom_range(0, 9))
            0, 1: gap = $urandom_range(1, 11);
            2: sender_calm_left = $urandom_range(10, 40);
            default: ;
         endcase
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {5'b0, lvl_down, lvl_ok, lvl_up, now_ms};
      req_tuser  <= clr;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) begin
         input_stall_cycles++;
         @(posedge clock);
      end
      pending_results.push_back(classify_poll(now_ms, lvl_up, lvl_ok, lvl_down, clr));
      polls_sent++;
      if (clr) clears_sent++;
   endtask

   // sender goes quiet until every predicted word has come back
   task automatic wait_results_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // writes all three timing registers; only called with the block idle
   task automatic load_timing(input logic [CFG_W-1:0] deb_val, long_val, panic_val);
      csr_wr_en <= 1'b1;
      csr_index <= REG_DEBOUNCE;
      csr_wdata <= deb_val;
      @(posedge clock);
      csr_index <= REG_LONG_PRESS;
      csr_wdata <= long_val;
      @(posedge clock);
      csr_index <= REG_PANIC_HOLD;
      csr_wdata <= panic_val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      debounce_cfg = deb_val;
      long_cfg     = long_val;
      panic_cfg    = panic_val;
   endtask

   // button activity: steady time steps, toggles, chords, glitches, clears, jumps
   task automatic run_poll_stream(input int count, input int step_max);
      logic [31:0] delta;
      logic        lvl [NUM_BUTTONS];
      int          pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 4) delta = $urandom;
         else if (pick < 20) delta = $urandom_range(0, 60);
         else delta = $urandom_range(0, step_max);
         stream_ms = stream_ms + delta;
         if (chord_left > 0) begin
            chord_left--;
            for (int b = 0; b < NUM_BUTTONS; b++) target_pressed[b] = 1'b1;
         end else if ($urandom_range(0, 39) == 0) begin
            chord_left = $urandom_range(8, 30);
            for (int b = 0; b < NUM_BUTTONS; b++) target_pressed[b] = 1'b1;
         end else begin
            for (int b = 0; b < NUM_BUTTONS; b++)
               if ($urandom_range(0, 6) == 0) target_pressed[b] = !target_pressed[b];
         end
         for (int b = 0; b < NUM_BUTTONS; b++) lvl[b] = target_pressed[b] ? PRESS : FREE;
         // one-poll glitch on a single pin
         if ($urandom_range(0, 19) == 0) begin
            pick = $urandom_range(0, NUM_BUTTONS - 1);
            lvl[pick] = !lvl[pick];
         end
         // pure noise on the pins
         if ($urandom_range(0, 29) == 0)
            for (int b = 0; b < NUM_BUTTONS; b++) lvl[b] = 1'($urandom_range(0, 1));
         send_poll(stream_ms, lvl[0], lvl[1], lvl[2], $urandom_range(0, 39) == 0);
      end
   endtask

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   // default timing: debounce after reset, long hold, short releases per lane
   task automatic test_short_and_long();
      send_poll(32'd0,    FREE,  FREE,  FREE,  1'b0);
      send_poll(32'd10,   PRESS, FREE,  FREE,  1'b0);  // too soon after reset edge
      send_poll(32'd100,  PRESS, FREE,  FREE,  1'b0);
      send_poll(32'd950,  PRESS, FREE,  FREE,  1'b0);  // up long
      send_poll(32'd1000, FREE,  FREE,  FREE,  1'b0);  // no short after long
      send_poll(32'd1100, FREE,  PRESS, FREE,  1'b0);
      send_poll(32'd1200, FREE,  FREE,  FREE,  1'b0);  // ok short
      send_poll(32'd1300, FREE,  FREE,  PRESS, 1'b0);
      send_poll(32'd1400, FREE,  FREE,  FREE,  1'b0);  // down short
   endtask

   // all three held: longs in scan order, panic, re-arm, then clear
   task automatic test_panic_and_clear();
      send_poll(32'd2000, PRESS, PRESS, PRESS, 1'b0);
      send_poll(32'd2900, PRESS, PRESS, PRESS, 1'b0);  // down long wins
      send_poll(32'd5000, PRESS, PRESS, PRESS, 1'b0);  // panic
      send_poll(32'd5001, PRESS, PRESS, PRESS, 1'b0);  // timer restarts
      send_poll(32'd5002, PRESS, PRESS, PRESS, 1'b1);  // clear
      send_poll(32'd5100, FREE,  FREE,  FREE,  1'b0);
   endtask

   // time differences across the 32-bit wrap
   task automatic test_time_wrap();
      send_poll(32'hFFFF_FFF0, PRESS, FREE, FREE, 1'b0);
      send_poll(32'h0000_0040, FREE,  FREE, FREE, 1'b0);  // 80 ms later: short
      send_poll(32'h0000_0050, PRESS, FREE, FREE, 1'b0);  // 16 ms: rejected
      wait_results_drained();
   endtask

   // panic hold that begins at timestamp zero, then all-zero and all-max timing
   task automatic test_timing_extremes();
      load_timing(16'd0, 16'd100, 16'd20);
      send_poll(32'd0,  PRESS, PRESS, PRESS, 1'b0);
      send_poll(32'd10, PRESS, PRESS, PRESS, 1'b0);
      send_poll(32'd20, PRESS, PRESS, PRESS, 1'b0);   // panic from a zero start
      send_poll(32'd20, PRESS, PRESS, PRESS, 1'b0);
      wait_results_drained();
      load_timing(16'd0, 16'd0, 16'd0);
      send_poll(32'd7, PRESS, PRESS, PRESS, 1'b0);
      send_poll(32'd8, FREE,  FREE,  FREE,  1'b0);
      wait_results_drained();
      load_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_poll(32'd9,      PRESS, FREE, FREE, 1'b0);  // debounce not met
      send_poll(32'd65543,  PRESS, FREE, FREE, 1'b0);  // exactly the debounce time
      send_poll(32'd131078, PRESS, FREE, FREE, 1'b0);  // exactly the long time
      wait_results_drained();
   endtask

   task automatic test_random_defaults();
      load_timing(DEBOUNCE_DEFAULT, LONG_PRESS_DEFAULT, PANIC_HOLD_DEFAULT);
      run_poll_stream(250, 400);
      wait_results_drained();
   endtask

   task automatic test_random_short_times();
      load_timing(CFG_W'($urandom_range(0, 20)), CFG_W'($urandom_range(0, 200)),
                  CFG_W'($urandom_range(0, 400)));
      run_poll_stream(250, 60);
      wait_results_drained();
   endtask

   // receiver holds off while polls keep coming, so the input must stall
   task automatic test_output_backpressure();
      sender_idle_en = 1'b0;
      rsp_hold_left  = 60;
      run_poll_stream(40, 100);
      wait_results_drained();
      sender_idle_en = 1'b1;
   endtask

   task automatic test_random_config_sweep();
      logic [CFG_W-1:0] d, l, p;
      load_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
      run_poll_stream(120, 40000);
      wait_results_drained();
      load_timing(16'd0, 16'd0, 16'd0);
      run_poll_stream(80, 50);
      wait_results_drained();
      d = CFG_W'($urandom_range(0, 16'hFFFF));
      l = CFG_W'($urandom_range(0, 16'hFFFF));
      p = CFG_W'($urandom_range(0, 16'hFFFF));
      load_timing(d, l, p);
      run_poll_stream(150, int'(p) / 4 + 20);
      wait_results_drained();
   endtask

   // closing stretch with both sides always ready
   task automatic test_full_rate();
      load_timing(DEBOUNCE_DEFAULT, 16'd300, 16'd900);
      sender_idle_en   = 1'b0;
      receiver_idle_en = 1'b0;
      run_poll_stream(160, 150);
   endtask

   initial begin
      reset_predictor();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_short_and_long();
      test_panic_and_clear();
      test_time_wrap();
      test_timing_extremes();
      test_random_defaults();
      test_random_short_times();
      test_output_backpressure();
      test_random_config_sweep();
      test_full_rate();

      wait_results_drained();
      repeat (10) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch($sformatf("%0d predicted words never arrived", pending_results.size()));

      $display("Covered %0d polls (%0d clears), %0d result words, %0d input stall cycles",
               polls_sent, clears_sent, results_checked, input_stall_cycles);
      $display("Events: none %0d, short %0d/%0d/%0d, long %0d/%0d/%0d, panic %0d",
               event_tally[0], event_tally[1], event_tally[2], event_tally[3],
               event_tally[4], event_tally[5], event_tally[6], event_tally[7]);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

`default_nettype wire
